// ===== hw/rtl/eph_pkg.sv =====
// Package for the Ethernet/IPv4/L4 header parser.
// Holds the status codes, protocol numbers and fixed header offsets.
// No dependencies.
package eph_pkg;

	typedef enum logic [2:0] {
		ST_UDP          = 3'd0,
		ST_TCP          = 3'd1,
		ST_SHORT_ETH    = 3'd2,
		ST_SHORT_IP     = 3'd3,
		ST_SHORT_IPOPTS = 3'd4,
		ST_SHORT_UDP    = 3'd5,
		ST_SHORT_TCP    = 3'd6,
		ST_OTHER        = 3'd7
	} status_t;

	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_TCP = 8'd6;

	localparam int ETH_BYTES     = 14;
	localparam int IP_MIN_BYTES  = 20;
	localparam int UDP_BYTES     = 8;
	localparam int TCP_MIN_BYTES = 20;

	localparam int IHL_POS      = 14;
	localparam int PROTO_POS    = 23;
	localparam int SRC_IP_FIRST = 26;
	localparam int SRC_IP_LAST  = 29;
	localparam int DST_IP_FIRST = 30;
	localparam int DST_IP_LAST  = 33;
	localparam int TCP_OFF_POS  = 12;

	localparam int TDATA_W = 136;

endpackage

// ===== hw/rtl/eth_ipv4_l4_header_parser_core.sv =====
// Top level of the Ethernet/IPv4/L4 header parser: byte stream in, one
// summary word per frame out. Depends on eph_pkg.
//
// channel   dir  signals                       payload
// s_*       in   s_tvalid s_tready s_tdata     data_byte [7:0], last_byte on s_tlast
// m_*       out  m_tvalid m_tready m_tdata     summary fields, status on m_tuser
// cfg_*     in   cfg_valid cfg_ready cfg_data  strip_hdr
//
// One byte per cycle while no last byte is held; a byte goes through an input register and
// the capture/summary logic, and a frame's summary is then registered in the output register.
// Only the last byte of a frame waits on m_tready; other bytes stall only behind a held last byte.
// Reset clears the byte counter, captured fields and valid flags.
module eth_ipv4_l4_header_parser_core #(
	parameter int MAX_FRAME_BYTES = 16383
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] src_addr, [63:32] dst_addr, [79:64] sport, [95:80] dport,
	// [111:96] l4_length, [119:112] header_bytes, [133:120] kept_length, [135:134] zero
	output logic [eph_pkg::TDATA_W-1:0]   m_tdata,
	output logic [2:0]                    m_tuser,   // [2:0] status
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data   // [0] strip_hdr
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int XW = CW + 1;

	logic          valid_s1, last_s1;
	logic [7:0]    data_s1;
	logic          strip_q;
	logic [CW-1:0] count_q;
	logic [3:0]    ip_words_q, tcp_words_q;
	logic [7:0]    proto_q;
	logic [31:0]   src_ip_q, dst_ip_q;
	logic [15:0]   sport_q, dport_q, udp_len_q;

	logic          out_valid_q;
	logic [eph_pkg::TDATA_W-1:0] out_data_q;
	logic [2:0]    out_status_q;

	logic          out_free, s1_fire, in_fire, cap_en;
	logic [CW-1:0] pos, l4_pos;
	logic [3:0]    ipw_eff;
	logic [3:0]    ip_words_d, tcp_words_d;
	logic [7:0]    proto_d;
	logic [31:0]   src_ip_d, dst_ip_d;
	logic [15:0]   sport_d, dport_d, udp_len_d;
	logic [CW-1:0] count_inc;

	logic [XW-1:0] len_x, iplen_x, th_x, rem_x;
	eph_pkg::status_t status;
	logic          addrs_ok, parsed;
	logic [7:0]    hdr;
	logic [15:0]   l4len;
	logic [13:0]   kept;

	assign out_free = !out_valid_q || m_tready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_fire;
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			data_s1  <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				last_s1  <= s_tlast;
				data_s1  <= s_tdata;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			strip_q <= cfg_data;
		end
	end

	// capture logic for the byte in stage 1
	assign pos       = count_q;
	assign cap_en    = count_q < CW'(MAX_FRAME_BYTES);
	assign count_inc = cap_en ? count_q + CW'(1) : count_q;
	assign ipw_eff   = (pos == CW'(eph_pkg::IHL_POS)) ? data_s1[3:0] : ip_words_q;
	assign l4_pos    = CW'(eph_pkg::ETH_BYTES) + CW'({ipw_eff, 2'b00});

	always_comb begin
		ip_words_d  = ip_words_q;
		proto_d     = proto_q;
		src_ip_d    = src_ip_q;
		dst_ip_d    = dst_ip_q;
		sport_d     = sport_q;
		dport_d     = dport_q;
		udp_len_d   = udp_len_q;
		tcp_words_d = tcp_words_q;
		if (cap_en) begin
			if (pos == CW'(eph_pkg::IHL_POS))
				ip_words_d = data_s1[3:0];
			if (pos == CW'(eph_pkg::PROTO_POS))
				proto_d = data_s1;
			if (pos >= CW'(eph_pkg::SRC_IP_FIRST) && pos <= CW'(eph_pkg::SRC_IP_LAST))
				src_ip_d = {src_ip_q[23:0], data_s1};
			if (pos >= CW'(eph_pkg::DST_IP_FIRST) && pos <= CW'(eph_pkg::DST_IP_LAST))
				dst_ip_d = {dst_ip_q[23:0], data_s1};
			if (pos == l4_pos || pos == l4_pos + CW'(1))
				sport_d = {sport_q[7:0], data_s1};
			if (pos == l4_pos + CW'(2) || pos == l4_pos + CW'(3))
				dport_d = {dport_q[7:0], data_s1};
			if (pos == l4_pos + CW'(4) || pos == l4_pos + CW'(5))
				udp_len_d = {udp_len_q[7:0], data_s1};
			if (pos == l4_pos + CW'(eph_pkg::TCP_OFF_POS))
				tcp_words_d = data_s1[7:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ip_words_q  <= '0;
			proto_q     <= '0;
			src_ip_q    <= '0;
			dst_ip_q    <= '0;
			sport_q     <= '0;
			dport_q     <= '0;
			udp_len_q   <= '0;
			tcp_words_q <= '0;
		end else if (s1_fire) begin
			count_q     <= last_s1 ? '0 : count_inc;
			ip_words_q  <= ip_words_d;
			proto_q     <= proto_d;
			src_ip_q    <= src_ip_d;
			dst_ip_q    <= dst_ip_d;
			sport_q     <= sport_d;
			dport_q     <= dport_d;
			udp_len_q   <= udp_len_d;
			tcp_words_q <= tcp_words_d;
		end
	end

	// frame summary from the updated captures
	assign len_x   = XW'(count_inc);
	assign iplen_x = XW'({ip_words_d, 2'b00});
	assign th_x    = XW'({tcp_words_d, 2'b00});
	assign rem_x   = len_x - XW'(eph_pkg::ETH_BYTES) - iplen_x;

	always_comb begin
		status   = eph_pkg::ST_OTHER;
		addrs_ok = 1'b1;
		hdr      = '0;
		l4len    = '0;
		priority if (len_x < XW'(eph_pkg::ETH_BYTES)) begin
			status   = eph_pkg::ST_SHORT_ETH;
			addrs_ok = 1'b0;
		end else if (len_x < XW'(eph_pkg::ETH_BYTES + eph_pkg::IP_MIN_BYTES)) begin
			status   = eph_pkg::ST_SHORT_IP;
			addrs_ok = 1'b0;
		end else if (len_x < XW'(eph_pkg::ETH_BYTES) + iplen_x) begin
			status = eph_pkg::ST_SHORT_IPOPTS;
		end else if (proto_d == eph_pkg::PROTO_UDP) begin
			if (rem_x < XW'(eph_pkg::UDP_BYTES)) begin
				status = eph_pkg::ST_SHORT_UDP;
			end else begin
				status = eph_pkg::ST_UDP;
				l4len  = udp_len_d;
				hdr    = 8'(eph_pkg::ETH_BYTES + eph_pkg::UDP_BYTES) + {2'b00, ip_words_d, 2'b00};
			end
		end else if (proto_d == eph_pkg::PROTO_TCP) begin
			if (rem_x < XW'(eph_pkg::TCP_MIN_BYTES)) begin
				status = eph_pkg::ST_SHORT_TCP;
			end else begin
				status = eph_pkg::ST_TCP;
				l4len  = (rem_x > th_x) ? 16'(rem_x - th_x) : 16'd0;
				hdr    = 8'(eph_pkg::ETH_BYTES) + {2'b00, ip_words_d, 2'b00}
					+ {2'b00, tcp_words_d, 2'b00};
			end
		end else begin
			status = eph_pkg::ST_OTHER;
		end
	end

	assign parsed = (status == eph_pkg::ST_UDP) || (status == eph_pkg::ST_TCP);
	assign kept   = (strip_q && parsed) ? {6'd0, hdr} : 14'(count_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_status_q <= status;
			out_data_q   <= {2'b00, kept, hdr, l4len,
				parsed ? dport_d : 16'd0,
				parsed ? sport_d : 16'd0,
				addrs_ok ? dst_ip_d : 32'd0,
				addrs_ok ? src_ip_d : 32'd0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule
